@@ rtl/bfz_pkg.sv @@
package bfz_pkg;

	localparam int NUM_BITS = 1024;
	localparam int SIZE_W = 11;
	localparam int IDX_W = 10;
	localparam int OP_W = 2;

	localparam int CELL_BITS = (NUM_BITS < 128) ? NUM_BITS : 128;
	localparam int NUM_CELLS = NUM_BITS / CELL_BITS;
	localparam int OFF_W = (CELL_BITS > 1) ? $clog2(CELL_BITS) : 1;
	localparam int POS_W = $clog2(NUM_BITS);
	localparam int LIM_W = $clog2(NUM_BITS + 1);
	localparam int CNT_W = $clog2(NUM_CELLS + 1);

	localparam logic [OP_W-1:0] OP_SET = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [IDX_W-1:0] bit_index;
	} req_item_t;

	typedef struct packed {
		logic bit_value;
		logic [IDX_W-1:0] first_unset;
		logic found;
		logic all_set;
		logic out_of_range;
	} rsp_item_t;

	typedef struct packed {
		logic en;
		logic value;
		logic [LIM_W-1:0] word;
		logic [OFF_W-1:0] offset;
	} wr_cmd_t;

	typedef struct packed {
		logic found;
		logic [POS_W-1:0] pos;
	} link_t;

endpackage

@@ rtl/bfz_cell.sv @@
module bfz_cell (
	input logic clk,
	input logic arst_n,
	input logic [bfz_pkg::LIM_W-1:0] base,
	input logic [bfz_pkg::LIM_W-1:0] lim,
	input bfz_pkg::wr_cmd_t wr,
	input bfz_pkg::link_t link_in,
	output bfz_pkg::link_t link_out,
	output logic [bfz_pkg::CELL_BITS-1:0] bits
);
	import bfz_pkg::*;

	logic [CELL_BITS-1:0] bits_q;
	logic [CELL_BITS-1:0] vmask;
	logic [CELL_BITS-1:0] masked;
	logic [LIM_W:0] top_edge;
	logic [LIM_W-1:0] diff;
	logic local_found;
	logic [OFF_W-1:0] local_pos;
	link_t link_q;

	assign top_edge = {1'b0, base} + (LIM_W + 1)'(CELL_BITS);
	assign diff = lim - base;

	always_comb begin
		if ({1'b0, lim} >= top_edge) begin
			vmask = '1;
		end else if (lim <= base) begin
			vmask = '0;
		end else begin
			vmask = ~({CELL_BITS{1'b1}} << diff[OFF_W-1:0]);
		end
	end

	// Bits outside the size in use count as set, so the search skips them.
	assign masked = bits_q | ~vmask;

	always_comb begin
		local_found = 1'b0;
		local_pos = '0;
		for (int b = CELL_BITS - 1; b >= 0; b--) begin
			if (!masked[b]) begin
				local_found = 1'b1;
				local_pos = OFF_W'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (wr.en && (wr.word == (base >> OFF_W))) begin
			bits_q[wr.offset] <= wr.value;
		end
	end

	// A lower cell's hit always wins over this cell's own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (link_in.found) begin
			link_q <= link_in;
		end else begin
			link_q.found <= local_found;
			link_q.pos <= local_found ? (POS_W'(base) | POS_W'(local_pos)) : '0;
		end
	end

	assign link_out = link_q;
	assign bits = bits_q;

endmodule

@@ rtl/bitmap_allocator_find_first_zero.sv @@
// Channel   Direction  Handshake              Item
// req       in         req_valid / req_ready  operation, bit_index
// rsp       out        rsp_valid / rsp_ready  bit_value, first_unset, found, all_set, out_of_range
// cfg       in         cfg_valid / cfg_ready  size_in_use
//
// Each request's search result passes one cell per cycle through the chain of cells (1024 bits
// in cells of 128); the response is registered once the last cell holds the answer and any
// earlier response has been taken. The next request is taken only after that, not during the search.
// The store is updated at the edge that accepts the request.
// Reset clears the whole store and sets the size in use to 1024; no clearing pass is needed.
// A finished response waits in its own register, so a new request is taken while it stalls.
module bitmap_allocator_find_first_zero (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input bfz_pkg::req_item_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output bfz_pkg::rsp_item_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bfz_pkg::SIZE_W-1:0] cfg_data
);
	import bfz_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [LIM_W-1:0] lim;
	logic req_fire;
	logic oor;
	logic [POS_W-1:0] idx_pos;
	logic [NUM_BITS-1:0] store_bits;
	wr_cmd_t wr;
	link_t links [NUM_CELLS+1];

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic bit_value_q;
	logic oor_q;
	logic rsp_valid_q;
	rsp_item_t rsp_q;
	logic done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1024);
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	assign lim = (32'(size_q) > NUM_BITS) ? LIM_W'(NUM_BITS) : LIM_W'(size_q);

	assign req_ready = !busy_q;
	assign req_fire = req_valid && req_ready;
	assign oor = (req.operation != OP_FIND) && (32'(req.bit_index) >= 32'(lim));
	assign idx_pos = POS_W'(req.bit_index);

	always_comb begin
		wr.en = req_fire && !oor &&
			((req.operation == OP_SET) || (req.operation == OP_CLEAR));
		wr.value = (req.operation == OP_SET);
		wr.word = LIM_W'(idx_pos >> OFF_W);
		wr.offset = OFF_W'(idx_pos);
	end

	assign links[0] = '0;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		bfz_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.base(LIM_W'(c * CELL_BITS)),
			.lim(lim),
			.wr(wr),
			.link_in(links[c]),
			.link_out(links[c+1]),
			.bits(store_bits[c*CELL_BITS +: CELL_BITS])
		);
	end

	// The last cell holds the final answer once the chain has run through every cell.
	assign done = busy_q && (cnt_q == CNT_W'(NUM_CELLS)) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req_fire) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && (cnt_q != CNT_W'(NUM_CELLS))) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			bit_value_q <= (req.operation == OP_READ) && !oor && store_bits[idx_pos];
			oor_q <= oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q.bit_value <= bit_value_q;
			rsp_q.first_unset <= IDX_W'(links[NUM_CELLS].pos);
			rsp_q.found <= links[NUM_CELLS].found;
			rsp_q.all_set <= !links[NUM_CELLS].found;
			rsp_q.out_of_range <= oor_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
